// ===== rtl/core/ssh_kexinit_stream_parser_macros.svh =====
// Assertion helpers used by the parser top level.
`ifndef SSH_KEXINIT_STREAM_PARSER_MACROS_SVH
`define SSH_KEXINIT_STREAM_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sshkex_pkg.sv =====
package sshkex_pkg;

    typedef enum logic [7:0] {
        PH_LINE_START = 8'b0000_0001,
        PH_IN_LINE    = 8'b0000_0010,
        PH_HEADER     = 8'b0000_0100,
        PH_MSG_ID     = 8'b0000_1000,
        PH_COOKIE     = 8'b0001_0000,
        PH_LIST_LEN   = 8'b0010_0000,
        PH_LIST_DATA  = 8'b0100_0000,
        PH_IDLE       = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_PACKET  = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_BAD_ID     = 3'd3,
        ST_OVERRUN    = 3'd4,
        ST_TRUNCATED  = 3'd5
    } status_t;

    localparam logic [7:0]  MSG_KEXINIT   = 8'd20;
    localparam logic [7:0]  PACKET_MARK   = 8'h00;
    localparam logic [7:0]  LINE_FEED     = 8'h0A;
    localparam logic [31:0] COOKIE_LEN    = 32'd16;
    localparam logic [3:0]  LIST_LAST     = 4'd9;
    localparam logic [2:0]  LEN_LAST_BYTE = 3'd3;
    localparam logic [2:0]  HDR_BYTES     = 3'd4;
    // Packet length must reach padding + 1 + minimum payload of 17.
    localparam logic [24:0] MIN_PLEN_OFS  = 25'd18;

    typedef struct packed {
        logic [7:0] list_byte;
        logic       byte_valid;
        logic [3:0] list_index;
        logic       list_end;
        logic       parse_done;
        status_t    parse_status;
    } result_t;

    typedef struct packed {
        logic       at_line_start;
        logic [3:0] current_list;
    } core_stat_t;

endpackage

// ===== rtl/core/sshkex_step.sv =====
module sshkex_step (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_take,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    output sshkex_pkg::result_t    res,
    output sshkex_pkg::core_stat_t stat
);

    sshkex_pkg::phase_t  phase_reg, phase_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [23:0]         plen_reg, plen_next;
    logic [23:0]         pay_reg, pay_next;
    logic [31:0]         lrem_reg, lrem_next;
    logic [3:0]          cur_reg, cur_next;
    sshkex_pkg::status_t err_reg, err_next;

    logic [23:0] pay_dec;
    logic [31:0] lrem_dec;
    logic [31:0] lrem_len;
    logic        pay_counts;

    assign pay_counts = (phase_reg != sshkex_pkg::PH_LINE_START) &&
                        (phase_reg != sshkex_pkg::PH_IN_LINE) &&
                        (phase_reg != sshkex_pkg::PH_HEADER);
    assign pay_dec  = (pay_counts && pay_reg != 24'd0) ? pay_reg - 24'd1 : pay_reg;
    assign lrem_dec = (lrem_reg != 32'd0) ? lrem_reg - 32'd1 : lrem_reg;
    assign lrem_len = (cnt_reg == 3'd0) ? {24'd0, in_byte} : {lrem_reg[23:0], in_byte};

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        plen_next  = plen_reg;
        pay_next   = pay_dec;
        lrem_next  = lrem_reg;
        cur_next   = cur_reg;
        err_next   = err_reg;
        res        = '0;
        res.parse_status = sshkex_pkg::ST_OK;

        case (phase_reg)
            sshkex_pkg::PH_LINE_START: begin
                if (in_byte == sshkex_pkg::PACKET_MARK) begin
                    plen_next  = 24'd0;
                    cnt_next   = 3'd1;
                    phase_next = sshkex_pkg::PH_HEADER;
                end else if (in_byte != sshkex_pkg::LINE_FEED) begin
                    phase_next = sshkex_pkg::PH_IN_LINE;
                end
            end
            sshkex_pkg::PH_IN_LINE: begin
                if (in_byte == sshkex_pkg::LINE_FEED) begin
                    phase_next = sshkex_pkg::PH_LINE_START;
                end
            end
            sshkex_pkg::PH_HEADER: begin
                if (cnt_reg < sshkex_pkg::HDR_BYTES) begin
                    plen_next = {plen_reg[15:0], in_byte};
                    cnt_next  = cnt_reg + 3'd1;
                end else if ({1'b0, plen_reg} <
                             ({17'd0, in_byte} + sshkex_pkg::MIN_PLEN_OFS)) begin
                    err_next   = sshkex_pkg::ST_BAD_LENGTH;
                    phase_next = sshkex_pkg::PH_IDLE;
                end else begin
                    pay_next   = plen_reg - {16'd0, in_byte} - 24'd1;
                    phase_next = sshkex_pkg::PH_MSG_ID;
                end
            end
            sshkex_pkg::PH_MSG_ID: begin
                if (in_byte != sshkex_pkg::MSG_KEXINIT) begin
                    err_next   = sshkex_pkg::ST_BAD_ID;
                    phase_next = sshkex_pkg::PH_IDLE;
                end else begin
                    lrem_next  = sshkex_pkg::COOKIE_LEN;
                    phase_next = sshkex_pkg::PH_COOKIE;
                end
            end
            sshkex_pkg::PH_COOKIE: begin
                lrem_next = lrem_dec;
                if (lrem_dec == 32'd0) begin
                    cur_next   = 4'd0;
                    cnt_next   = 3'd0;
                    phase_next = sshkex_pkg::PH_LIST_LEN;
                end
            end
            sshkex_pkg::PH_LIST_LEN: begin
                lrem_next = lrem_len;
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == sshkex_pkg::LEN_LAST_BYTE) begin
                    if (lrem_len > {8'd0, pay_dec}) begin
                        err_next   = sshkex_pkg::ST_OVERRUN;
                        phase_next = sshkex_pkg::PH_IDLE;
                    end else if (lrem_len == 32'd0) begin
                        res.list_end   = 1'b1;
                        res.list_index = cur_reg;
                        if (cur_reg >= sshkex_pkg::LIST_LAST) begin
                            phase_next = sshkex_pkg::PH_IDLE;
                        end else begin
                            cur_next   = cur_reg + 4'd1;
                            cnt_next   = 3'd0;
                            phase_next = sshkex_pkg::PH_LIST_LEN;
                        end
                    end else begin
                        phase_next = sshkex_pkg::PH_LIST_DATA;
                    end
                end
            end
            sshkex_pkg::PH_LIST_DATA: begin
                res.list_byte  = in_byte;
                res.byte_valid = 1'b1;
                res.list_index = cur_reg;
                lrem_next      = lrem_dec;
                if (lrem_dec == 32'd0) begin
                    res.list_end = 1'b1;
                    if (cur_reg >= sshkex_pkg::LIST_LAST) begin
                        phase_next = sshkex_pkg::PH_IDLE;
                    end else begin
                        cur_next   = cur_reg + 4'd1;
                        cnt_next   = 3'd0;
                        phase_next = sshkex_pkg::PH_LIST_LEN;
                    end
                end
            end
            default: begin
            end
        endcase

        // Running out of payload while lists are still open is an overrun.
        if ((phase_next == sshkex_pkg::PH_LIST_LEN || phase_next == sshkex_pkg::PH_LIST_DATA)
            && pay_dec == 24'd0) begin
            err_next   = sshkex_pkg::ST_OVERRUN;
            phase_next = sshkex_pkg::PH_IDLE;
        end

        if (in_last) begin
            res.parse_done = 1'b1;
            if (phase_next == sshkex_pkg::PH_LINE_START ||
                phase_next == sshkex_pkg::PH_IN_LINE) begin
                res.parse_status = sshkex_pkg::ST_NO_PACKET;
            end else if (phase_next == sshkex_pkg::PH_HEADER) begin
                res.parse_status = sshkex_pkg::ST_TRUNCATED;
            end else if (err_next == sshkex_pkg::ST_BAD_LENGTH) begin
                res.parse_status = sshkex_pkg::ST_BAD_LENGTH;
            end else if (pay_next != 24'd0) begin
                res.parse_status = sshkex_pkg::ST_TRUNCATED;
            end else begin
                res.parse_status = err_next;
            end
            phase_next = sshkex_pkg::PH_LINE_START;
            cnt_next   = 3'd0;
            plen_next  = 24'd0;
            pay_next   = 24'd0;
            lrem_next  = 32'd0;
            cur_next   = 4'd0;
            err_next   = sshkex_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sshkex_pkg::PH_LINE_START;
            cnt_reg   <= 3'd0;
            plen_reg  <= 24'd0;
            pay_reg   <= 24'd0;
            lrem_reg  <= 32'd0;
            cur_reg   <= 4'd0;
            err_reg   <= sshkex_pkg::ST_OK;
        end else if (in_take) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            plen_reg  <= plen_next;
            pay_reg   <= pay_next;
            lrem_reg  <= lrem_next;
            cur_reg   <= cur_next;
            err_reg   <= err_next;
        end
    end

    assign stat.at_line_start = (phase_reg == sshkex_pkg::PH_LINE_START);
    assign stat.current_list  = cur_reg;

endmodule

// ===== rtl/core/ssh_kexinit_stream_parser.sv =====
// Parses the server side of an SSH connection start, one byte per word.
// The slave channel carries the raw receive buffer: s_tdata holds the byte and
// s_tlast marks the final byte of the buffer. Banner lines are skipped until a
// line starts with a zero byte, then the KEXINIT packet header, message id and
// cookie are checked and the ten name-lists are walked.
// The master channel gives exactly one word for every byte taken. Name-list
// content bytes are flagged by m_tuser, the byte that completes a list raises
// the list end bit, and m_tlast marks the word for the buffer's last byte,
// which also carries the parse status.
// m_tvalid rises in the cycle after acceptance; a byte can be taken every
// cycle unless the receiver stalls, the state set by a single pass of logic.
// While the receiver stalls, the result word is held and s_tready stays low
// until it is taken, unless it is taken in the same cycle.
// Reset returns the parser to the start of a banner line with no error and
// clears m_tvalid; after each last byte the same parser state is restored,
// so the next byte starts a new buffer.
`include "ssh_kexinit_stream_parser_macros.svh"

module ssh_kexinit_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] list_byte, [11:8] list_index,
                                   // [12] list_end, [15:13] parse_status
    output logic        m_tuser,   // [0] byte_valid
    output logic        m_tlast
);

    sshkex_pkg::result_t    step_res;
    sshkex_pkg::result_t    res_reg;
    sshkex_pkg::core_stat_t core_stat;
    logic                   m_tvalid_reg;
    logic                   s_acc;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    sshkex_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (s_acc),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .res     (step_res),
        .stat    (core_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_acc) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {res_reg.parse_status, res_reg.list_end, res_reg.list_index,
                       res_reg.list_byte};
    assign m_tuser  = res_reg.byte_valid;
    assign m_tlast  = res_reg.parse_done;

    `SKP_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, s_acc && s_tlast, core_stat.at_line_start && (core_stat.current_list == 4'd0), "parser state not cleared after the last byte")
    `SKP_ASSERT_SAME(a_list_range, aclk, aresetn, 1'b1, core_stat.current_list <= sshkex_pkg::LIST_LAST, "list counter beyond the last name-list")
    `SKP_ASSERT_SAME(a_status_on_last, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[15:13] == sshkex_pkg::ST_OK, "status reported on a word that is not the last")

endmodule

// ===== sim/tb_ssh_kexinit_stream_parser.sv =====
module tb_ssh_kexinit_stream_parser;
    import sshkex_pkg::*;

    localparam int          HALF_PERIOD    = 6;
    localparam int          RESET_CYCLES   = 12;
    localparam logic [31:0] MIN_PAYLOAD    = 32'd17;
    localparam int          LIST_COUNT     = 10;
    localparam int          LONG_HOLD      = 300;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          DRAIN_CYCLES   = 4;

    typedef enum {
        PK_GOOD,
        PK_BAD_ID,
        PK_LIST_OVERRUN,
        PK_SHORT_PAYLOAD,
        PK_TRUNCATED
    } pkt_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Parser state as seen by the predictor.
    phase_t      pstate;
    logic [2:0]  hdr_cnt;
    logic [31:0] pkt_len;
    logic [23:0] payload_left;
    logic [31:0] list_left;
    logic [3:0]  list_no;
    status_t     err_status;

    result_t     due_results[$];
    result_t     want_r;
    logic [7:0]  stream_q[$];

    logic        src_idle_en;
    logic        sink_idle_en;
    logic        hold_req;
    int          errors;
    int          words_in;
    int          buffers_sent;
    int          list_bytes_seen;
    int          list_ends_seen;
    int          status_seen[6];
    int          quiet_cycles;

    ssh_kexinit_stream_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    function automatic void clear_parser();
        pstate       = PH_LINE_START;
        hdr_cnt      = '0;
        pkt_len      = '0;
        payload_left = '0;
        list_left    = '0;
        list_no      = '0;
        err_status   = ST_OK;
    endfunction

    function automatic void advance_list();
        if (list_no >= LIST_LAST) begin
            pstate = PH_IDLE;
        end else begin
            list_no = list_no + 4'd1;
            hdr_cnt = '0;
            pstate  = PH_LIST_LEN;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        result_t     r;
        logic [31:0] wide_b;
        r      = '0;
        wide_b = {24'd0, b};
        if (pstate != PH_LINE_START && pstate != PH_IN_LINE && pstate != PH_HEADER &&
            payload_left != 24'd0) begin
            payload_left = payload_left - 24'd1;
        end
        case (pstate)
            PH_LINE_START: begin
                if (b == PACKET_MARK) begin
                    pkt_len = wide_b;
                    hdr_cnt = 3'd1;
                    pstate  = PH_HEADER;
                end else if (b != LINE_FEED) begin
                    pstate = PH_IN_LINE;
                end
            end
            PH_IN_LINE: begin
                if (b == LINE_FEED) begin
                    pstate = PH_LINE_START;
                end
            end
            PH_HEADER: begin
                if (hdr_cnt < HDR_BYTES) begin
                    pkt_len = {pkt_len[23:0], b};
                    hdr_cnt = hdr_cnt + 3'd1;
                end else if (pkt_len == 32'd0 || wide_b + 32'd1 > pkt_len ||
                             pkt_len - wide_b - 32'd1 < MIN_PAYLOAD) begin
                    err_status = ST_BAD_LENGTH;
                    pstate     = PH_IDLE;
                end else begin
                    payload_left = 24'(pkt_len - wide_b - 32'd1);
                    pstate       = PH_MSG_ID;
                end
            end
            PH_MSG_ID: begin
                if (b != MSG_KEXINIT) begin
                    err_status = ST_BAD_ID;
                    pstate     = PH_IDLE;
                end else begin
                    list_left = COOKIE_LEN;
                    pstate    = PH_COOKIE;
                end
            end
            PH_COOKIE: begin
                if (list_left != 32'd0) begin
                    list_left = list_left - 32'd1;
                end
                if (list_left == 32'd0) begin
                    list_no = '0;
                    hdr_cnt = '0;
                    pstate  = PH_LIST_LEN;
                end
            end
            PH_LIST_LEN: begin
                list_left = (hdr_cnt == 3'd0) ? wide_b : {list_left[23:0], b};
                hdr_cnt   = hdr_cnt + 3'd1;
                if (hdr_cnt >= HDR_BYTES) begin
                    if (list_left > {8'd0, payload_left}) begin
                        err_status = ST_OVERRUN;
                        pstate     = PH_IDLE;
                    end else if (list_left == 32'd0) begin
                        r.list_end   = 1'b1;
                        r.list_index = list_no;
                        advance_list();
                    end else begin
                        pstate = PH_LIST_DATA;
                    end
                end
            end
            PH_LIST_DATA: begin
                r.list_byte  = b;
                r.byte_valid = 1'b1;
                r.list_index = list_no;
                if (list_left != 32'd0) begin
                    list_left = list_left - 32'd1;
                end
                if (list_left == 32'd0) begin
                    r.list_end = 1'b1;
                    advance_list();
                end
            end
            default: begin
            end
        endcase

        if ((pstate == PH_LIST_LEN || pstate == PH_LIST_DATA) && payload_left == 24'd0) begin
            err_status = ST_OVERRUN;
            pstate     = PH_IDLE;
        end

        if (last) begin
            r.parse_done = 1'b1;
            if (pstate == PH_LINE_START || pstate == PH_IN_LINE) begin
                r.parse_status = ST_NO_PACKET;
            end else if (pstate == PH_HEADER) begin
                r.parse_status = ST_TRUNCATED;
            end else if (err_status == ST_BAD_LENGTH) begin
                r.parse_status = ST_BAD_LENGTH;
            end else if (payload_left != 24'd0) begin
                r.parse_status = ST_TRUNCATED;
            end else begin
                r.parse_status = err_status;
            end
            clear_parser();
        end
        due_results.push_back(r);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected, expected none, actual %h/%b/%b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want_r = due_results.pop_front();
                check_field("list_byte", want_r.list_byte, m_tdata[7:0]);
                check_field("byte_valid", want_r.byte_valid, m_tuser);
                check_field("list_index", want_r.list_index, m_tdata[11:8]);
                check_field("list_end", want_r.list_end, m_tdata[12]);
                check_field("parse_done", want_r.parse_done, m_tlast);
                check_field("parse_status", want_r.parse_status, m_tdata[15:13]);
                if (want_r.byte_valid) begin
                    list_bytes_seen++;
                end
                if (want_r.list_end) begin
                    list_ends_seen++;
                end
                if (want_r.parse_done) begin
                    status_seen[want_r.parse_status]++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or one long hold when asked for.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_word(input logic [7:0] d, input logic last);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        s_tlast  = last;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        parse_byte(d, last);
        words_in++;
        @(negedge aclk);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < stream_q.size(); i++) begin
            send_word(stream_q[i], i == stream_q.size() - 1);
        end
        buffers_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic shuffle_idling();
        src_idle_en  = $urandom_range(0, 2) != 0;
        sink_idle_en = $urandom_range(0, 2) != 0;
    endtask

    // Banner lines, a header, the KEXINIT body and padding, shaped by kind.
    task automatic make_buffer(input pkt_kind_t kind);
        int          lens[LIST_COUNT];
        int          sum_len;
        int          line_len;
        int          pad;
        int          cut;
        int          bad_list;
        logic [31:0] payload;
        logic [31:0] decl_payload;
        logic [31:0] plen;
        logic [31:0] len_field;
        logic [7:0]  c;
        logic [7:0]  body_q[$];
        stream_q.delete();
        body_q.delete();
        repeat ($urandom_range(0, 2)) begin
            line_len = $urandom_range(0, 6);
            for (int j = 0; j < line_len; j++) begin
                c = 8'($urandom_range(0, 255));
                while (c == LINE_FEED || (j == 0 && c == PACKET_MARK)) begin
                    c = 8'($urandom_range(0, 255));
                end
                stream_q.push_back(c);
            end
            stream_q.push_back(LINE_FEED);
        end
        sum_len = 0;
        for (int k = 0; k < LIST_COUNT; k++) begin
            lens[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
            sum_len += 4 + lens[k];
        end
        payload = MIN_PAYLOAD + 32'(sum_len);
        body_q.push_back((kind == PK_BAD_ID) ? MSG_KEXINIT + 8'($urandom_range(1, 255))
                                             : MSG_KEXINIT);
        repeat (COOKIE_LEN) body_q.push_back(8'($urandom));
        bad_list = $urandom_range(0, LIST_COUNT - 1);
        for (int k = 0; k < LIST_COUNT; k++) begin
            len_field = 32'(lens[k]);
            if (kind == PK_LIST_OVERRUN && k == bad_list) begin
                len_field = $urandom_range(0, 1) ? payload + 32'($urandom_range(1, 3))
                                                 : ($urandom | 32'h0100_0000);
            end
            body_q.push_back(len_field[31:24]);
            body_q.push_back(len_field[23:16]);
            body_q.push_back(len_field[15:8]);
            body_q.push_back(len_field[7:0]);
            repeat (lens[k]) body_q.push_back(8'($urandom));
        end
        decl_payload = (kind == PK_SHORT_PAYLOAD) ? $urandom_range(MIN_PAYLOAD, payload - 1)
                                                  : payload;
        pad  = $urandom_range(0, 8);
        plen = decl_payload + 32'(pad) + 32'd1;
        stream_q.push_back(PACKET_MARK);
        stream_q.push_back(plen[23:16]);
        stream_q.push_back(plen[15:8]);
        stream_q.push_back(plen[7:0]);
        stream_q.push_back(8'(pad));
        cut = stream_q.size() + $urandom_range(1, payload - 1);
        foreach (body_q[i]) stream_q.push_back(body_q[i]);
        repeat (pad) stream_q.push_back(8'($urandom));
        repeat ($urandom_range(0, 3)) stream_q.push_back(8'($urandom));
        if (kind == PK_TRUNCATED) begin
            while (stream_q.size() > cut) void'(stream_q.pop_back());
        end
    endtask

    task automatic test_banner_lines();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        stream_q = {LINE_FEED, 8'h53, PACKET_MARK, LINE_FEED, 8'hFF, LINE_FEED};
        send_buffer();
        stream_q = {8'h7F, PACKET_MARK};
        send_buffer();
        stream_q = {LINE_FEED, PACKET_MARK, PACKET_MARK, 8'h01};
        send_buffer();
        wait_drained();
    endtask

    task automatic test_header_checks();
        stream_q = {PACKET_MARK, 8'h00, 8'h00, 8'h00, 8'h05, MSG_KEXINIT};
        send_buffer();
        stream_q = {PACKET_MARK, 8'h00, 8'h00, 8'h04, 8'h04, MSG_KEXINIT};
        send_buffer();
        stream_q = {PACKET_MARK, 8'h00, 8'h00, 8'h14, 8'h04};
        send_buffer();
        stream_q = {PACKET_MARK, 8'h00, 8'h00, 8'h16, 8'h04, 8'h15};
        send_buffer();
        stream_q = {PACKET_MARK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, MSG_KEXINIT};
        send_buffer();
        wait_drained();
    endtask

    task automatic test_well_formed();
        while (words_in < 380) begin
            shuffle_idling();
            make_buffer(PK_GOOD);
            send_buffer();
        end
        wait_drained();
    endtask

    task automatic test_broken_packets();
        while (words_in < 600) begin
            shuffle_idling();
            make_buffer(pkt_kind_t'($urandom_range(PK_BAD_ID, PK_TRUNCATED)));
            send_buffer();
        end
        wait_drained();
    endtask

    task automatic test_noise();
        while (words_in < 680) begin
            shuffle_idling();
            stream_q.delete();
            repeat ($urandom_range(5, 40)) begin
                case ($urandom_range(0, 7))
                    0:       stream_q.push_back(LINE_FEED);
                    1:       stream_q.push_back(PACKET_MARK);
                    default: stream_q.push_back(8'($urandom));
                endcase
            end
            send_buffer();
        end
        wait_drained();
    endtask

    task automatic test_long_stall();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_req     = 1'b1;
        make_buffer(PK_GOOD);
        send_buffer();
        wait_drained();
        src_idle_en = 1'b1;
        make_buffer(PK_GOOD);
        send_buffer();
        wait_drained();
    endtask

    task automatic test_no_idle();
        int stop_at;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        stop_at      = (words_in + 100 > 1000) ? words_in + 100 : 1000;
        while (words_in < stop_at) begin
            make_buffer(($urandom_range(0, 1) == 0) ? PK_GOOD
                        : pkt_kind_t'($urandom_range(PK_BAD_ID, PK_TRUNCATED)));
            send_buffer();
        end
        wait_drained();
    endtask

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        src_idle_en     = 1'b0;
        sink_idle_en    = 1'b0;
        hold_req        = 1'b0;
        errors          = 0;
        words_in        = 0;
        buffers_sent    = 0;
        list_bytes_seen = 0;
        list_ends_seen  = 0;
        quiet_cycles    = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        clear_parser();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_banner_lines();
        test_header_checks();
        test_well_formed();
        test_broken_packets();
        test_noise();
        test_long_stall();
        test_no_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (due_results.size() != 0) begin
            errors++;
            $display("%0t: results outstanding, expected 0, actual %0d",
                     $time, due_results.size());
        end
        $display("Covered %0d buffers of %0d words: %0d list bytes and %0d list ends.",
                 buffers_sent, words_in, list_bytes_seen, list_ends_seen);
        $display("Status counts: ok %0d, no packet %0d, bad length %0d, bad id %0d, %s%0d, %s%0d",
                 status_seen[ST_OK], status_seen[ST_NO_PACKET], status_seen[ST_BAD_LENGTH],
                 status_seen[ST_BAD_ID], "overrun ", status_seen[ST_OVERRUN],
                 "truncated ", status_seen[ST_TRUNCATED]);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== ssh_kexinit_stream_parser.f =====
+incdir+rtl/core
rtl/core/sshkex_pkg.sv
rtl/core/sshkex_step.sv
rtl/core/ssh_kexinit_stream_parser.sv
sim/tb_ssh_kexinit_stream_parser.sv
